// ===== sv/iatpd_pkg.sv =====
// ----------------------------------------------------------------------------
// iatpd_pkg
// shared types and constants of the axial thrust peak detector
// ----------------------------------------------------------------------------
package iatpd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_US    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEFF    = 3'd3;

  localparam logic [14:0] PEAK_THRESHOLD_RST = 15'd4096;
  localparam logic [15:0] GYRO_LIMIT_RST     = 16'd1600;
  localparam logic [19:0] COOLDOWN_US_RST    = 20'd150000;
  localparam logic [15:0] DECAY_COEFF_RST    = 16'd58982;

  // gravity low-pass alpha, 0.10 in Q0.16
  localparam int GRAV_ALPHA = 6554;
  localparam logic signed [15:0] GRAV_ONE = 16'sd4096;

  localparam logic [16:0] ENV_FULL = 17'd65536;
  localparam logic [16:0] ENV_HALF = 17'd32768;

  // multiply schedule
  localparam int LAST_STEP = 29;

  typedef enum logic [1:0] {
    JS_ZERO = 2'd0,
    JS_POS  = 2'd1,
    JS_NEG  = 2'd2
  } jerk_sign_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_EVAL,
    ST_DIV,
    ST_DECAY,
    ST_DWB,
    ST_OUT
  } state_e;

endpackage

// ===== sv/iatpd_sample_if.sv =====
// ----------------------------------------------------------------------------
// iatpd_sample_if
// imu sample channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface iatpd_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [15:0]             quat_w;
  logic signed [15:0]             quat_x;
  logic signed [15:0]             quat_y;
  logic signed [15:0]             quat_z;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  logic signed [SAMPLE_WIDTH-1:0] gyro_x;
  logic signed [SAMPLE_WIDTH-1:0] gyro_y;
  logic signed [SAMPLE_WIDTH-1:0] gyro_z;
  logic [17:0]                    step_us;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
                  gyro_x, gyro_y, gyro_z, step_us, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
                  gyro_x, gyro_y, gyro_z, step_us, output ready);
endinterface

// ===== sv/iatpd_result_if.sv =====
// ----------------------------------------------------------------------------
// iatpd_result_if
// detector result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface iatpd_result_if;
  logic               valid;
  logic               ready;
  logic               thrust_fired;
  logic [16:0]        thrust_envelope;
  logic signed [17:0] axial_accel;

  modport source (output valid, thrust_fired, thrust_envelope, axial_accel, input ready);
  modport sink   (input valid, thrust_fired, thrust_envelope, axial_accel, output ready);
endinterface

// ===== sv/iatpd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// iatpd_cfg_if
// register write channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface iatpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/imu_axial_thrust_peak_detector_unit.sv =====
// ----------------------------------------------------------------------------
// imu_axial_thrust_peak_detector_unit
// axial thrust peak detector on one shared multiplier under a step sequencer
// ----------------------------------------------------------------------------
// sequence: request accept, 30 multiplier steps, eval, optional 16-step strength divider,
//   decay, writeback, then result valid until the result is taken
// a new request is taken only once the result has been taken; the single multiplier
//   and the bit-serial strength divider serve one request at a time, and output
//   stalls hold off the next request
// reset: async active low; registers to defaults, gravity (0,0,1g), other control state zero
// ----------------------------------------------------------------------------
module imu_axial_thrust_peak_detector_unit #(
  parameter int SAMPLE_WIDTH = iatpd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  iatpd_sample_if.sink          in_i,
  iatpd_result_if.source        out_o,
  iatpd_cfg_if.sink             cfg_i
);
  import iatpd_pkg::*;

  // difference width, multiplier operand and product widths, accumulator width, gyro sum width
  localparam int DW  = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1;
  localparam int MA  = DW + 7;
  localparam int MB  = (DW > 20) ? DW : 20;
  localparam int PW  = MA + MB;
  localparam int ACW = PW + 2;
  localparam int GW  = 2 * SAMPLE_WIDTH + 2;
  // gyro compare width, covers both the squared sum and the squared limit
  localparam int CW  = (GW > 32) ? GW : 32;

  // rounding right shift, half away from zero
  function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end
    return -((-v + half) >>> s);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [63:0] v);
    if (v > 64'sd131071) begin
      return 18'sh1ffff;
    end
    if (v < -64'sd131072) begin
      return 18'sh20000;
    end
    return 18'(v);
  endfunction

  // configuration registers
  logic [14:0] peak_thr_q;
  logic [15:0] gyro_lim_q;
  logic [19:0] cooldown_us_q;
  logic [15:0] decay_q;

  // sequencer
  state_e      state_q, state_d;
  logic [4:0]  step_q;
  logic [3:0]  div_cnt_q;

  // captured request
  logic signed [15:0]             qw_q, qx_q, qy_q, qz_q;
  logic signed [SAMPLE_WIDTH-1:0] acc_in_q [3];
  logic signed [SAMPLE_WIDTH-1:0] gyr_q [3];
  logic [17:0]                    dt_q;

  // working registers
  logic signed [31:0] p_q [10];
  logic signed [19:0] m_q [3][3];
  logic signed [15:0] t_q [3];
  logic signed [MA-1:0] wv_q [3];
  logic signed [PW-1:0] prod_q;
  logic signed [ACW-1:0] acc_q;
  logic [GW-1:0]      gacc_q;
  logic [31:0]        glim2_q;
  logic [16:0]        rem_q;
  logic [15:0]        quo_q;
  logic               fired_q;

  // detector state
  logic signed [15:0] g_q [3];
  logic signed [17:0] axial_q;
  logic signed [17:0] last_axial_q;
  jerk_sign_e         last_js_q;
  logic [20:0]        cool_left_q;
  logic [16:0]        env_q;

  // result register
  logic               res_fired_q;
  logic [16:0]        res_env_q;
  logic signed [17:0] res_axial_q;

  logic in_fire, out_fire, last_div;

  // ---------------------------------------------------------------- handshakes
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = (state_q == ST_OUT);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid & in_i.ready;
  assign out_fire    = out_o.valid & out_o.ready;
  assign last_div    = (div_cnt_q == 4'd15);

  assign out_o.thrust_fired    = res_fired_q;
  assign out_o.thrust_envelope = res_env_q;
  assign out_o.axial_accel     = res_axial_q;

  // ---------------------------------------------------------------- rotation matrix
  // products: ww xx yy zz xy wz xz wy yz wx, matrix entries Q.28
  logic signed [33:0] r [3][3];
  always_comb begin
    r[0][0] = 34'(p_q[0]) + 34'(p_q[1]) - 34'(p_q[2]) - 34'(p_q[3]);
    r[0][1] = (34'(p_q[4]) - 34'(p_q[5])) <<< 1;
    r[0][2] = (34'(p_q[6]) + 34'(p_q[7])) <<< 1;
    r[1][0] = (34'(p_q[4]) + 34'(p_q[5])) <<< 1;
    r[1][1] = 34'(p_q[0]) - 34'(p_q[1]) + 34'(p_q[2]) - 34'(p_q[3]);
    r[1][2] = (34'(p_q[8]) - 34'(p_q[9])) <<< 1;
    r[2][0] = (34'(p_q[6]) - 34'(p_q[7])) <<< 1;
    r[2][1] = (34'(p_q[8]) + 34'(p_q[9])) <<< 1;
    r[2][2] = 34'(p_q[0]) - 34'(p_q[1]) - 34'(p_q[2]) + 34'(p_q[3]);
  end

  // gravity step input and gravity-free acceleration
  logic signed [16:0]   gdiff [3];
  logic signed [DW-1:0] d_w [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gdiff[i] = 17'(t_q[i]) - 17'(g_q[i]);
      d_w[i]   = DW'(acc_in_q[i]) - DW'(g_q[i]);
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  logic signed [MA-1:0] op_a;
  logic signed [MB-1:0] op_b;
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_q == ST_DECAY) begin
      op_a = MA'(signed'({1'b0, env_q}));
      op_b = MB'(signed'({1'b0, decay_q}));
    end else if (state_q == ST_RUN) begin
      case (step_q)
        5'd0:  begin op_a = MA'(qw_q); op_b = MB'(qw_q); end
        5'd1:  begin op_a = MA'(qx_q); op_b = MB'(qx_q); end
        5'd2:  begin op_a = MA'(qy_q); op_b = MB'(qy_q); end
        5'd3:  begin op_a = MA'(qz_q); op_b = MB'(qz_q); end
        5'd4:  begin op_a = MA'(qx_q); op_b = MB'(qy_q); end
        5'd5:  begin op_a = MA'(qw_q); op_b = MB'(qz_q); end
        5'd6:  begin op_a = MA'(qx_q); op_b = MB'(qz_q); end
        5'd7:  begin op_a = MA'(qw_q); op_b = MB'(qy_q); end
        5'd8:  begin op_a = MA'(qy_q); op_b = MB'(qz_q); end
        5'd9:  begin op_a = MA'(qw_q); op_b = MB'(qx_q); end
        5'd10: begin op_a = MA'(gyr_q[0]); op_b = MB'(gyr_q[0]); end
        5'd11: begin op_a = MA'(gyr_q[1]); op_b = MB'(gyr_q[1]); end
        5'd12: begin op_a = MA'(gdiff[0]); op_b = MB'(GRAV_ALPHA); end
        5'd13: begin op_a = MA'(gdiff[1]); op_b = MB'(GRAV_ALPHA); end
        5'd14: begin op_a = MA'(gdiff[2]); op_b = MB'(GRAV_ALPHA); end
        5'd15: begin
          op_a = MA'(signed'({1'b0, gyro_lim_q}));
          op_b = MB'(signed'({1'b0, gyro_lim_q}));
        end
        5'd16: begin op_a = MA'(m_q[0][0]); op_b = MB'(d_w[0]); end
        5'd17: begin op_a = MA'(m_q[0][1]); op_b = MB'(d_w[1]); end
        5'd18: begin op_a = MA'(m_q[0][2]); op_b = MB'(d_w[2]); end
        5'd19: begin op_a = MA'(m_q[1][0]); op_b = MB'(d_w[0]); end
        5'd20: begin op_a = MA'(m_q[1][1]); op_b = MB'(d_w[1]); end
        5'd21: begin op_a = MA'(m_q[1][2]); op_b = MB'(d_w[2]); end
        5'd22: begin op_a = MA'(m_q[2][0]); op_b = MB'(d_w[0]); end
        5'd23: begin op_a = MA'(m_q[2][1]); op_b = MB'(d_w[1]); end
        5'd24: begin op_a = MA'(m_q[2][2]); op_b = MB'(d_w[2]); end
        5'd25: begin op_a = MA'(gyr_q[2]); op_b = MB'(gyr_q[2]); end
        // tip is the first matrix column
        5'd26: begin op_a = wv_q[0]; op_b = MB'(m_q[0][0]); end
        5'd27: begin op_a = wv_q[1]; op_b = MB'(m_q[1][0]); end
        5'd28: begin op_a = wv_q[2]; op_b = MB'(m_q[2][0]); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  // ---------------------------------------------------------------- peak decision
  logic signed [ACW-1:0] acc_sum;
  jerk_sign_e            js;
  logic [20:0]           cool_dec;
  logic signed [18:0]    thr_s;
  logic                  pos_peak, neg_peak, fire;
  logic [18:0]           mag;
  logic [17:0]           rem0;
  logic [16:0]           div_d;
  logic [17:0]           rem_sh;
  logic [15:0]           quo_next;
  logic [16:0]           rem_next;
  logic [17:0]           env_sum;

  always_comb begin
    acc_sum = acc_q + ACW'(prod_q);
    if (axial_q > last_axial_q) begin
      js = JS_POS;
    end else if (axial_q < last_axial_q) begin
      js = JS_NEG;
    end else begin
      js = JS_ZERO;
    end
    // countdown saturates at zero
    if (cool_left_q > 21'(dt_q)) begin
      cool_dec = cool_left_q - 21'(dt_q);
    end else begin
      cool_dec = '0;
    end
    thr_s    = 19'(signed'({1'b0, peak_thr_q}));
    pos_peak = (19'(axial_q) > thr_s) && (last_js_q == JS_POS) && (js != JS_POS);
    neg_peak = (19'(axial_q) < -thr_s) && (last_js_q == JS_NEG) && (js != JS_NEG);
    fire     = (pos_peak || neg_peak) && (CW'(gacc_q) < CW'(glim2_q)) &&
               (cool_dec == '0);
    mag      = axial_q[17] ? 19'(-19'(axial_q)) : 19'(axial_q);
    rem0     = 18'(mag - 19'(peak_thr_q));
    div_d    = 17'(peak_thr_q) * 17'd3;
    // restoring divider step
    rem_sh   = {rem_q, 1'b0};
    if (rem_sh >= 18'(div_d)) begin
      rem_next = 17'(rem_sh - 18'(div_d));
      quo_next = {quo_q[14:0], 1'b1};
    end else begin
      rem_next = rem_sh[16:0];
      quo_next = {quo_q[14:0], 1'b0};
    end
    env_sum  = 18'(quo_next) + 18'(ENV_HALF);
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_RUN;
      ST_RUN:   if (step_q == 5'(LAST_STEP)) state_d = ST_EVAL;
      ST_EVAL: begin
        if (fire && (18'(rem0) < 18'(div_d))) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_DECAY;
        end
      end
      ST_DIV:   if (last_div) state_d = ST_DECAY;
      ST_DECAY: state_d = ST_DWB;
      ST_DWB:   state_d = ST_OUT;
      ST_OUT:   if (out_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_thr_q    <= PEAK_THRESHOLD_RST;
      gyro_lim_q    <= GYRO_LIMIT_RST;
      cooldown_us_q <= COOLDOWN_US_RST;
      decay_q       <= DECAY_COEFF_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_PEAK_THRESHOLD: peak_thr_q    <= cfg_i.data[14:0];
        REG_GYRO_LIMIT:     gyro_lim_q    <= cfg_i.data[15:0];
        REG_COOLDOWN_US:    cooldown_us_q <= cfg_i.data;
        REG_DECAY_COEFF:    decay_q       <= cfg_i.data[15:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      div_cnt_q <= '0;
    end else begin
      if (in_fire) begin
        step_q <= '0;
      end else if (state_q == ST_RUN) begin
        step_q <= step_q + 5'd1;
      end
      if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + 4'd1;
      end else begin
        div_cnt_q <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q[0]       <= '0;
      g_q[1]       <= '0;
      g_q[2]       <= GRAV_ONE;
      last_axial_q <= '0;
      last_js_q    <= JS_ZERO;
      cool_left_q  <= '0;
      env_q        <= '0;
      fired_q      <= 1'b0;
    end else begin
      if (state_q == ST_RUN) begin
        // gravity one-pole smoothing, results of steps 12 to 14
        case (step_q)
          5'd13: g_q[0] <= sat16(64'(g_q[0]) + rsh(64'(prod_q), 16));
          5'd14: g_q[1] <= sat16(64'(g_q[1]) + rsh(64'(prod_q), 16));
          5'd15: g_q[2] <= sat16(64'(g_q[2]) + rsh(64'(prod_q), 16));
          default: ;
        endcase
      end
      if (state_q == ST_EVAL) begin
        last_axial_q <= axial_q;
        last_js_q    <= js;
        fired_q      <= fire;
        if (fire) begin
          cool_left_q <= 21'(cooldown_us_q);
          env_q       <= ENV_FULL;  // overwritten by the divider when strength is partial
        end else begin
          cool_left_q <= cool_dec;
        end
      end
      if (state_q == ST_DIV && last_div) begin
        env_q <= (env_sum > 18'(ENV_FULL)) ? ENV_FULL : env_sum[16:0];
      end
      if (state_q == ST_DWB) begin
        env_q <= 17'(prod_q >>> 16);
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(op_a) * PW'(op_b);
    if (in_fire) begin
      qw_q        <= in_i.quat_w;
      qx_q        <= in_i.quat_x;
      qy_q        <= in_i.quat_y;
      qz_q        <= in_i.quat_z;
      acc_in_q[0] <= in_i.accel_x;
      acc_in_q[1] <= in_i.accel_y;
      acc_in_q[2] <= in_i.accel_z;
      gyr_q[0]    <= in_i.gyro_x;
      gyr_q[1]    <= in_i.gyro_y;
      gyr_q[2]    <= in_i.gyro_z;
      dt_q        <= in_i.step_us;
    end
    if (state_q == ST_RUN) begin
      // each step retires the product registered by the step before it
      if (step_q >= 5'd1 && step_q <= 5'd10) begin
        p_q[4'(step_q - 5'd1)] <= 32'(prod_q);
      end
      case (step_q)
        5'd11: begin
          gacc_q <= GW'(prod_q);
          for (int i = 0; i < 3; i++) begin
            t_q[i] <= sat16(rsh(64'(r[2][i]), 16));
            for (int j = 0; j < 3; j++) begin
              m_q[i][j] <= 20'(rsh(64'(r[i][j]), 14));
            end
          end
        end
        5'd12, 5'd26: gacc_q <= gacc_q + GW'(prod_q);
        5'd16: glim2_q <= 32'(prod_q);
        5'd17, 5'd20, 5'd23, 5'd27: acc_q <= ACW'(prod_q);
        5'd18, 5'd21, 5'd24, 5'd28: acc_q <= acc_sum;
        5'd19: wv_q[0] <= MA'(rsh(64'(acc_sum), 14));
        5'd22: wv_q[1] <= MA'(rsh(64'(acc_sum), 14));
        5'd25: wv_q[2] <= MA'(rsh(64'(acc_sum), 14));
        5'd29: axial_q <= sat18(rsh(64'(acc_sum), 14));
        default: ;
      endcase
    end
    if (state_q == ST_EVAL) begin
      rem_q <= rem0[16:0];
      quo_q <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
    end
    if (state_q == ST_DWB) begin
      res_fired_q <= fired_q;
      res_env_q   <= 17'(prod_q >>> 16);
      res_axial_q <= axial_q;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("request taken while a result is pending");

  a_fire_cool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.thrust_fired) |-> (cool_left_q == 21'(cooldown_us_q)))
    else $error("thrust without cooldown reload");

  a_env_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= ENV_FULL)
    else $error("envelope above full scale");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= 5'(LAST_STEP)))
    else $error("sequencer step out of range");

endmodule
